/* hdl/assert_macros.svh */
// Assertion macros for the S-record line loader.
// Included by files that carry concurrent assertions; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
`define SRLL_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define SRLL_NEVER(lbl, clk, rst_n, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define SRLL_ASSERT(lbl, clk, rst_n, prop, msg)
`define SRLL_NEVER(lbl, clk, rst_n, cond, msg)
`endif

`endif

/* hdl/srll_pkg.sv */
// Types, constants and the hex digit decoder of the S-record line loader.
// No dependencies.
package srll_pkg;

  localparam logic [7:0] CHAR_S      = 8'h53;
  localparam logic [7:0] CHAR_ZERO   = 8'h30;
  localparam logic [7:0] CHAR_ONE    = 8'h31;
  localparam logic [7:0] CHAR_THREE  = 8'h33;
  localparam logic [7:0] SUM_GOOD    = 8'hFF;

  typedef enum logic [2:0] {
    PH_IGNORE = 3'd0,
    PH_TYPE   = 3'd1,
    PH_COUNT  = 3'd2,
    PH_ADDR   = 3'd3,
    PH_DATA   = 3'd4,
    PH_CHECK  = 3'd5
  } phase_e;

  typedef enum logic [1:0] {
    RK_WRITE = 2'd0,
    RK_GOOD  = 2'd1,
    RK_ERROR = 2'd2
  } result_kind_e;

  typedef struct packed {
    logic       first;
    logic       is_s;
    logic       type_ok;
    logic [1:0] type_val;
    logic [3:0] nib;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  function automatic logic [3:0] hex_value(input logic [7:0] c);
    logic [3:0] v;
    v = 4'd0;
    if (c >= CHAR_ZERO && c <= 8'h39) v = 4'(c - CHAR_ZERO);
    else if (c >= 8'h41 && c <= 8'h46) v = 4'(c - 8'h37);
    else if (c >= 8'h61 && c <= 8'h66) v = 4'(c - 8'h57);
    return v;
  endfunction

endpackage

/* hdl/srll_char_if.sv */
// Character channel: one line character per beat with its line-start flag.
// No dependencies.
interface srll_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] character;
  logic       line_start;

  modport source (output valid, output character, output line_start, input ready);
  modport sink   (input valid, input character, input line_start, output ready);
endinterface

/* hdl/srll_result_if.sv */
// Result channel: one memory byte write or record status per beat.
// No dependencies.
interface srll_result_if;
  logic        valid;
  logic        ready;
  logic [1:0]  result_kind;
  logic [31:0] write_address;
  logic [7:0]  write_data;

  modport source (output valid, output result_kind, output write_address,
                  output write_data, input ready);
  modport sink   (input valid, input result_kind, input write_address,
                  input write_data, output ready);
endinterface

/* hdl/srll_front.sv */
// Front end: accepts characters and classifies them into parser commands.
// Depends on srll_pkg and srll_char_if.
module srll_front
  import srll_pkg::*;
(
  srll_char_if.sink in_i,
  input  q_stat_t   q_stat_i,
  output logic      push_o,
  output cmd_t      push_data_o
);

  assign in_i.ready = !q_stat_i.full;
  assign push_o     = in_i.valid && !q_stat_i.full;

  always_comb begin
    push_data_o.first    = in_i.line_start;
    push_data_o.is_s     = (in_i.character == CHAR_S);
    push_data_o.type_ok  = (in_i.character >= CHAR_ONE) && (in_i.character <= CHAR_THREE);
    push_data_o.type_val = in_i.character[1:0];
    push_data_o.nib      = hex_value(in_i.character);
  end

endmodule

/* hdl/srll_queue.sv */
// Command queue between the front end and the record parser.
// Depends on srll_pkg.
module srll_queue
  import srll_pkg::*;
#(
  parameter int Depth = 2
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    push_i,
  input  cmd_t    push_data_i,
  input  logic    pop_i,
  output cmd_t    pop_data_o,
  output q_stat_t stat_o
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  cmd_t            mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;

  assign stat_o.full  = (cnt_q == FullCnt);
  assign stat_o.empty = (cnt_q == '0);
  assign pop_data_o   = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
    if (pop_i)  rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
    if (push_i && !pop_i) cnt_d = cnt_q + 1'b1;
    else if (pop_i && !push_i) cnt_d = cnt_q - 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_ptr_q] <= push_data_i;
  end

endmodule

/* hdl/srll_back.sv */
// Back end: S-record parser state machine with the registered result beat.
// Depends on srll_pkg and srll_result_if.
module srll_back
  import srll_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  cmd_t      cmd_i,
  input  q_stat_t   q_stat_i,
  output logic      pop_o,
  srll_result_if.source res_o
);

  phase_e       phase_q, phase_d;
  logic [1:0]   rtype_q, rtype_d;
  logic [7:0]   bleft_q, bleft_d;
  logic [3:0]   adl_q, adl_d;
  logic [31:0]  la_q, la_d;
  logic [7:0]   sum_q, sum_d;
  logic [3:0]   high_q, high_d;
  logic         pend_q, pend_d;
  logic         ovalid_q, ovalid_d;
  result_kind_e kind_q, kind_d;
  logic [31:0]  oaddr_q, oaddr_d;
  logic [7:0]   odata_q, odata_d;

  logic [7:0]   pair;
  logic [7:0]   hdr_len;
  logic [7:0]   sum_new;

  assign pair    = {high_q, cmd_i.nib};
  assign hdr_len = 8'(rtype_q) + 8'd2;
  assign sum_new = sum_q + pair;
  assign pop_o   = !q_stat_i.empty && (!ovalid_q || res_o.ready);

  assign res_o.valid         = ovalid_q;
  assign res_o.result_kind   = kind_q;
  assign res_o.write_address = oaddr_q;
  assign res_o.write_data    = odata_q;

  always_comb begin
    phase_d  = phase_q;
    rtype_d  = rtype_q;
    bleft_d  = bleft_q;
    adl_d    = adl_q;
    la_d     = la_q;
    sum_d    = sum_q;
    high_d   = high_q;
    pend_d   = pend_q;
    ovalid_d = ovalid_q && !res_o.ready;
    kind_d   = kind_q;
    oaddr_d  = oaddr_q;
    odata_d  = odata_q;
    if (pop_o) begin
      if (cmd_i.first) begin
        rtype_d = '0;
        bleft_d = '0;
        adl_d   = '0;
        la_d    = '0;
        sum_d   = '0;
        high_d  = '0;
        pend_d  = 1'b0;
        phase_d = cmd_i.is_s ? PH_TYPE : PH_IGNORE;
      end else begin
        if (phase_q == PH_COUNT || phase_q == PH_ADDR || phase_q == PH_DATA ||
            phase_q == PH_CHECK) begin
          pend_d = !pend_q;
          if (!pend_q) high_d = cmd_i.nib;
        end
        unique case (phase_q)
          PH_TYPE: begin
            if (cmd_i.type_ok) begin
              rtype_d = cmd_i.type_val;
              phase_d = PH_COUNT;
            end else begin
              phase_d = PH_IGNORE;
            end
          end
          PH_COUNT: begin
            if (pend_q) begin
              sum_d   = pair;
              bleft_d = (pair > hdr_len) ? pair - hdr_len : 8'd0;
              adl_d   = {3'(rtype_q) + 3'd1, 1'b0};
              phase_d = PH_ADDR;
            end
          end
          PH_ADDR: begin
            la_d  = {la_q[27:0], cmd_i.nib};
            adl_d = adl_q - 4'd1;
            if (pend_q) sum_d = sum_new;
            if (adl_q == 4'd1) phase_d = (bleft_q != 8'd0) ? PH_DATA : PH_CHECK;
          end
          PH_DATA: begin
            if (pend_q) begin
              ovalid_d = 1'b1;
              kind_d   = RK_WRITE;
              oaddr_d  = la_q;
              odata_d  = pair;
              sum_d    = sum_new;
              la_d     = la_q + 32'd1;
              bleft_d  = bleft_q - 8'd1;
              if (bleft_q == 8'd1) phase_d = PH_CHECK;
            end
          end
          PH_CHECK: begin
            if (pend_q) begin
              ovalid_d = 1'b1;
              kind_d   = (sum_new == SUM_GOOD) ? RK_GOOD : RK_ERROR;
              oaddr_d  = '0;
              odata_d  = '0;
              sum_d    = sum_new;
              phase_d  = PH_IGNORE;
            end
          end
          default: phase_d = PH_IGNORE;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_IGNORE;
      rtype_q  <= '0;
      bleft_q  <= '0;
      adl_q    <= '0;
      la_q     <= '0;
      sum_q    <= '0;
      high_q   <= '0;
      pend_q   <= 1'b0;
      ovalid_q <= 1'b0;
    end else begin
      phase_q  <= phase_d;
      rtype_q  <= rtype_d;
      bleft_q  <= bleft_d;
      adl_q    <= adl_d;
      la_q     <= la_d;
      sum_q    <= sum_d;
      high_q   <= high_d;
      pend_q   <= pend_d;
      ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q  <= kind_d;
    oaddr_q <= oaddr_d;
    odata_q <= odata_d;
  end

endmodule

/* hdl/srecord_line_loader_unit.sv */
// Top level of the S-record line loader: front end, command queue, parser.
// Depends on srll_pkg, srll_char_if, srll_result_if, srll_front, srll_queue,
// srll_back and assert_macros.svh.
//
// Takes one character of an S-record text line per beat and parses S1, S2
// and S3 records, issuing one byte write beat per data byte and a good or
// error status beat once the checksum byte is in; other lines give nothing.
// The front end classifies each character into a queue of QueueDepth entries
// and the parser retires one queue entry per cycle into an output register,
// so one character per cycle is sustained as long as the result side takes
// its beats.
`include "assert_macros.svh"

module srecord_line_loader_unit
  import srll_pkg::*;
#(
  parameter int QueueDepth = 2
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  srll_char_if.sink     in_i,
  srll_result_if.source out_o
);

  logic    push, pop;
  cmd_t    push_data, pop_data;
  q_stat_t q_stat;

  srll_front u_front (
    .in_i        (in_i),
    .q_stat_i    (q_stat),
    .push_o      (push),
    .push_data_o (push_data)
  );

  srll_queue #(.Depth(QueueDepth)) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .pop_i       (pop),
    .pop_data_o  (pop_data),
    .stat_o      (q_stat)
  );

  srll_back u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cmd_i    (pop_data),
    .q_stat_i (q_stat),
    .pop_o    (pop),
    .res_o    (out_o)
  );

  `SRLL_ASSERT(a_status_zero_payload, clk_i, rst_ni, (out_o.valid && out_o.result_kind != RK_WRITE) |-> (out_o.write_address == 32'd0 && out_o.write_data == 8'd0), "status beat carries nonzero payload")
  `SRLL_ASSERT(a_push_fills_queue, clk_i, rst_ni, (push && !pop) |=> !q_stat.empty, "queue empty after an unmatched push")
  `SRLL_NEVER(a_pop_empty, clk_i, rst_ni, pop && q_stat.empty, "pop from empty queue")
  `SRLL_ASSERT(a_taken_clears, clk_i, rst_ni, (out_o.valid && out_o.ready && !pop) |=> !out_o.valid, "result beat repeated")

endmodule
